/* design/psat_pkg.sv */
// Package for the packet sequence and acknowledgement tracker.
// Holds operation, status and register codes plus sizing constants.
// Has no dependencies; used by packet_sequence_ack_tracker.
package psat_pkg;

  // Width of the received mask in bits, and the index width into it.
  localparam int unsigned SeqMaskBits = 32;
  localparam int unsigned SeqIdxW     = $clog2(SeqMaskBits);

  // Default depth of the acknowledged mask.
  localparam int unsigned AckWindowDef = 64;

  localparam int unsigned SeqW      = 32;
  localparam int unsigned MaxDiffW  = 31;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [MaxDiffW-1:0] MaxSeqDiffRst = 31'd1024;
  localparam logic [SeqW-1:0]     MagicRst      = 32'd0;

  typedef enum logic [1:0] {
    OpRecv  = 2'd0,
    OpSend  = 2'd1,
    OpQuery = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StValid    = 3'd0,
    StBadMagic = 3'd1,
    StSeqFar   = 3'd2,
    StDup      = 3'd3,
    StAckFar   = 3'd4,
    StAckOld   = 3'd5,
    StAckNew   = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxSeqDiff = 2'd0,
    CfgMagic      = 2'd1
  } cfg_reg_e;

endpackage

/* design/packet_sequence_ack_tracker.sv */
// Packet sequence and acknowledgement tracker, top level.
// Depends on psat_pkg for codes and sizing constants.
//
// The block takes one word per cycle and returns one result word for each. A
// word is captured in an input register; the header checks, the mask shifts
// and the state update happen in the single cycle in which it moves to the
// result register, and a new word can be accepted every cycle while no held
// result blocks it. The only limit on rate is the downstream side: a held
// result stalls the input register, and the input stalls only while the input
// register holds a word that cannot move on.
// Receive words check magic, sequence distance, duplicates and ack distance,
// and update both masks if a newer header passes; send words advance the local
// sequence number; query words test the acknowledged mask. Configuration
// writes are always ready and take effect at once; write them only while idle.
module packet_sequence_ack_tracker #(
  parameter int unsigned AckWindow = psat_pkg::AckWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psat_pkg::CfgDataW-1:0] cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [31:0]                   hdr_magic_i,
  input  logic [31:0]                   hdr_seq_i,
  input  logic [31:0]                   hdr_ack_i,
  input  logic [31:0]                   query_seq_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [31:0]                   out_seq_o,
  output logic [31:0]                   out_ack_o,
  output logic [31:0]                   out_ack_bits_o,
  output logic                          acked_o
);
  import psat_pkg::*;

  localparam int unsigned AckIdxW = (AckWindow > 1) ? $clog2(AckWindow) : 1;

  // Configuration registers.
  logic [MaxDiffW-1:0] max_seq_diff_q;
  logic [SeqW-1:0]     magic_q;

  // Link state.
  logic [SeqW-1:0]        lseq_q, lseq_d;
  logic [SeqW-1:0]        rseq_q, rseq_d;
  logic [SeqMaskBits-1:0] rmask_q, rmask_d;
  logic [SeqW-1:0]        rack_q, rack_d;
  logic [AckWindow-1:0]   amask_q, amask_d;

  // Input register.
  logic            in_full_q;
  logic [1:0]      operation_q;
  logic [SeqW-1:0] hdr_magic_q, hdr_seq_q, hdr_ack_q, query_seq_q;

  // Result register.
  logic            out_full_q;
  logic [2:0]      status_q, status_d;
  logic [SeqW-1:0] out_seq_q, out_seq_d;
  logic [SeqW-1:0] out_ack_q, out_ack_d;
  logic [SeqW-1:0] out_bits_q, out_bits_d;
  logic            acked_q, acked_d;

  logic advance;
  logic in_take;
  logic newer;

  assign advance     = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o  = in_full_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seq_diff_q <= MaxSeqDiffRst;
      magic_q        <= MagicRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMaxSeqDiff: max_seq_diff_q <= cfg_data_i[MaxDiffW-1:0];
        CfgMagic:      magic_q        <= cfg_data_i[SeqW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [SeqW-1:0] max_d;
    logic [SeqW-1:0] up, down, seq_dist, dist_m1;
    logic [SeqW-1:0] rad, rad_m1;
    logic [SeqW-1:0] qdiff, qdiff_m1;

    max_d    = {1'b0, max_seq_diff_q};
    up       = hdr_seq_q - rseq_q;
    down     = rseq_q - hdr_seq_q;
    seq_dist = (up < down) ? up : down;
    dist_m1  = seq_dist - 32'd1;
    rad      = hdr_ack_q - rack_q;
    rad_m1   = rad - 32'd1;
    qdiff    = rack_q - query_seq_q;
    qdiff_m1 = qdiff - 32'd1;
    newer    = (up <= max_d);

    lseq_d     = lseq_q;
    rseq_d     = rseq_q;
    rmask_d    = rmask_q;
    rack_d     = rack_q;
    amask_d    = amask_q;
    status_d   = StValid;
    out_seq_d  = '0;
    out_ack_d  = '0;
    out_bits_d = '0;
    acked_d    = 1'b0;

    case (op_e'(operation_q))
      OpRecv: begin
        if (hdr_magic_q != magic_q) begin
          status_d = StBadMagic;
        end else if (seq_dist > max_d) begin
          status_d = StSeqFar;
        end else if (seq_dist == '0) begin
          status_d = StDup;
        end else if (!newer && seq_dist < 32'(SeqMaskBits) &&
                     rmask_q[dist_m1[SeqIdxW-1:0]]) begin
          status_d = StDup;
        end else if ((lseq_q - hdr_ack_q) > max_d) begin
          status_d = StAckFar;
        end else if (newer && rad > max_d) begin
          status_d = StAckOld;
        end else if (!newer && (rack_q - hdr_ack_q) > max_d) begin
          status_d = StAckNew;
        end else if (newer) begin
          // Slide both windows forward and mark the old newest entries.
          if (seq_dist < 32'(SeqMaskBits)) begin
            rmask_d = (rmask_q << seq_dist[SeqIdxW-1:0]) |
                      (SeqMaskBits'(1) << dist_m1[SeqIdxW-1:0]);
          end else begin
            rmask_d = '0;
          end
          rseq_d = hdr_seq_q;
          if (rad < 32'(AckWindow)) begin
            amask_d = amask_q << rad[AckIdxW-1:0];
            if (rad != '0) begin
              amask_d[rad_m1[AckIdxW-1:0]] = 1'b1;
            end
          end else begin
            amask_d = '0;
          end
          rack_d = hdr_ack_q;
        end else if (seq_dist <= 32'(SeqMaskBits)) begin
          // A late arrival only fills its hole in the received mask.
          rmask_d = rmask_q | (SeqMaskBits'(1) << dist_m1[SeqIdxW-1:0]);
        end
      end
      OpSend: begin
        lseq_d     = lseq_q + 32'd1;
        out_seq_d  = lseq_q + 32'd1;
        out_ack_d  = rseq_q;
        out_bits_d = rmask_q;
      end
      OpQuery: begin
        if (qdiff == '0) begin
          acked_d = 1'b1;
        end else if (qdiff <= 32'(AckWindow)) begin
          acked_d = amask_q[qdiff_m1[AckIdxW-1:0]];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lseq_q     <= '0;
      rseq_q     <= '0;
      rmask_q    <= '0;
      rack_q     <= '0;
      amask_q    <= '0;
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      if (advance) begin
        lseq_q  <= lseq_d;
        rseq_q  <= rseq_d;
        rmask_q <= rmask_d;
        rack_q  <= rack_d;
        amask_q <= amask_d;
      end
      if (in_take) begin
        in_full_q <= 1'b1;
      end else if (advance) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_full_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      operation_q <= operation_i;
      hdr_magic_q <= hdr_magic_i;
      hdr_seq_q   <= hdr_seq_i;
      hdr_ack_q   <= hdr_ack_i;
      query_seq_q <= query_seq_i;
    end
    if (advance) begin
      status_q   <= status_d;
      out_seq_q  <= out_seq_d;
      out_ack_q  <= out_ack_d;
      out_bits_q <= out_bits_d;
      acked_q    <= acked_d;
    end
  end

  assign out_valid_o    = out_full_q;
  assign status_o       = status_q;
  assign out_seq_o      = out_seq_q;
  assign out_ack_o      = out_ack_q;
  assign out_ack_bits_o = out_bits_q;
  assign acked_o        = acked_q;

`ifndef SYNTHESIS
  // A send result carries the local sequence number that it created.
  a_send_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && operation_q == OpSend |=> out_seq_o == lseq_q)
    else $error("send result does not match local sequence");

  // An accepted newer header becomes the newest remote sequence.
  a_newer_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && operation_q == OpRecv && status_d == StValid && newer
    |=> rseq_q == $past(hdr_seq_q))
    else $error("remote sequence not updated by newer header");

  // Link state only moves when a word passes to the result register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(lseq_q) && $stable(rseq_q) && $stable(rmask_q) &&
                 $stable(rack_q) && $stable(amask_q))
    else $error("link state changed without a word moving");

  // The input only stalls while a word waits in the input register.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_full_q && out_full_q && out_stall_i)
    else $error("input stalled without a blocked word");
`endif

endmodule
